// ===== hw/rtl/kti_pkg.sv =====
// Shared types and constants of the key table with insert and search operations.
`timescale 1ns / 1ps

package kti_pkg;

  // Input selector codes
  localparam logic [1:0] FUNC_INSERT    = 2'd0;
  localparam logic [1:0] FUNC_BINARY    = 2'd1;
  localparam logic [1:0] FUNC_LINEAR    = 2'd2;
  localparam logic [1:0] FUNC_TRANSPOSE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ORDERED  = 2'd0;
  localparam logic [1:0] REG_CAPACITY = 2'd1;
  localparam logic [1:0] REG_CLEAR    = 2'd2;

  localparam int FUNC_W      = 2;
  localparam int ST_W        = 2;
  localparam int POS_W       = 10;
  localparam int CMPS_W      = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD     = OUT_TDATA_W - POS_W - CMPS_W;

  localparam logic [CFG_DATA_W-1:0] CAP_RESET = 11'd1024;

  // Binary search reports BIN_BASE plus BIN_STEP per halving step.
  localparam int BIN_BASE = 2;
  localparam int BIN_STEP = 3;

  typedef struct packed {
    logic ordered;
    logic clear;
  } kti_ctl_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [POS_W-1:0]  position;
    logic [CMPS_W-1:0] comparisons;
  } kti_res_t;

endpackage

// ===== hw/rtl/kti_cmp.sv =====
// Shared key comparator: equality and signed greater-than.
`timescale 1ns / 1ps

module kti_cmp #(
  parameter int KEY_BITS = 32
) (
  input  logic [KEY_BITS-1:0] a,
  input  logic [KEY_BITS-1:0] b,
  output logic                eq,
  output logic                gt
);

  assign eq = (a == b);
  assign gt = ($signed(a) > $signed(b));

endmodule

// ===== hw/rtl/kti_seq.sv =====
// Sequencer that walks the key memory for insert, binary, linear and transpose search.
`timescale 1ns / 1ps

module kti_seq import kti_pkg::*; #(
  parameter int DEPTH    = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kti_ctl_t                     ctl,
  input  logic [$clog2(DEPTH+1)-1:0]   cap,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [FUNC_W-1:0]            in_func,
  input  logic [KEY_BITS-1:0]          in_key,
  output logic                         res_valid,
  input  logic                         res_ready,
  output kti_res_t                     res
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LH_W  = CNT_W + 1;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_INS_CMP = 7'b0000010,
    S_INS_PUT = 7'b0000100,
    S_BIN_CHK = 7'b0001000,
    S_BIN_CMP = 7'b0010000,
    S_LIN_CMP = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [LH_W-1:0]     lo_r, lo_nxt;
  logic [LH_W-1:0]     hi_r, hi_nxt;
  logic [CNT_W-1:0]    steps_r, steps_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [KEY_BITS-1:0] prev_r, prev_nxt;
  logic                trans_r, trans_nxt;
  logic                tput_r, tput_nxt;
  kti_res_t            res_r, res_nxt;

  logic [KEY_BITS-1:0] mem [DEPTH];
  logic [KEY_BITS-1:0] rdata_r;
  logic                rd_en, wr_en;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic [LH_W:0]       mid_sum;
  logic                hit, above;

  kti_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
    .a  (rdata_r),
    .b  (key_r),
    .eq (hit),
    .gt (above)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign mid_sum = (LH_W + 1)'(lo_r) + (LH_W + 1)'(hi_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    steps_nxt = steps_r;
    key_nxt   = key_r;
    prev_nxt  = prev_r;
    trans_nxt = trans_r;
    tput_nxt  = tput_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = key_r;

    case (state_r)
      S_IDLE: begin
        if (ctl.clear) begin
          cnt_nxt = '0;
        end
        if (in_valid) begin
          key_nxt   = in_key;
          trans_nxt = (in_func == FUNC_TRANSPOSE);
          tput_nxt  = 1'b0;
          case (in_func)
            FUNC_INSERT: begin
              if (cnt_r >= cap) begin
                res_nxt   = '{status: ST_FULL, position: '0, comparisons: '0};
                state_nxt = S_RESP;
              end else if (!ctl.ordered || cnt_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = cnt_r[IDX_W-1:0];
                wr_data   = in_key;
                cnt_nxt   = cnt_r + CNT_W'(1);
                res_nxt   = '{status: ST_OK, position: POS_W'(cnt_r),
                              comparisons: CMPS_W'(1)};
                state_nxt = S_RESP;
              end else begin
                idx_nxt   = cnt_r[IDX_W-1:0];
                rd_en     = 1'b1;
                rd_addr   = cnt_r[IDX_W-1:0] - IDX_W'(1);
                cnt_nxt   = cnt_r + CNT_W'(1);
                state_nxt = S_INS_CMP;
              end
            end
            FUNC_BINARY: begin
              lo_nxt    = '0;
              hi_nxt    = LH_W'(cnt_r) - LH_W'(1);
              steps_nxt = '0;
              state_nxt = S_BIN_CHK;
            end
            default: begin
              if (cnt_r == '0) begin
                res_nxt   = '{status: ST_NOT_FOUND, position: '0, comparisons: '0};
                state_nxt = S_RESP;
              end else begin
                idx_nxt   = '0;
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_LIN_CMP;
              end
            end
          endcase
        end
      end

      S_INS_CMP: begin
        // rdata_r holds the entry just below the open slot at idx_r.
        if (above) begin
          wr_en   = 1'b1;
          wr_addr = idx_r;
          wr_data = rdata_r;
          idx_nxt = idx_r - IDX_W'(1);
          if (idx_r == IDX_W'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r - IDX_W'(2);
          end
        end else begin
          state_nxt = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r;
        wr_data   = key_r;
        res_nxt   = '{status: ST_OK, position: POS_W'(idx_r),
                      comparisons: CMPS_W'(cnt_r - CNT_W'(idx_r))};
        state_nxt = S_RESP;
      end

      S_BIN_CHK: begin
        if ($signed(lo_r) <= $signed(hi_r)) begin
          idx_nxt   = mid_sum[IDX_W:1];
          rd_en     = 1'b1;
          rd_addr   = mid_sum[IDX_W:1];
          state_nxt = S_BIN_CMP;
        end else begin
          res_nxt   = '{status: ST_NOT_FOUND, position: '0, comparisons: '0};
          state_nxt = S_RESP;
        end
      end

      S_BIN_CMP: begin
        if (hit) begin
          res_nxt   = '{status: ST_OK, position: POS_W'(idx_r),
                        comparisons: CMPS_W'(BIN_BASE) +
                                     CMPS_W'(steps_r) * CMPS_W'(BIN_STEP)};
          state_nxt = S_RESP;
        end else begin
          if (above) begin
            hi_nxt = LH_W'(idx_r) - LH_W'(1);
          end else begin
            lo_nxt = LH_W'(idx_r) + LH_W'(1);
          end
          steps_nxt = steps_r + CNT_W'(1);
          state_nxt = S_BIN_CHK;
        end
      end

      S_LIN_CMP: begin
        if (tput_r) begin
          // Second half of a transpose: the found key moves one place down.
          wr_en     = 1'b1;
          wr_addr   = idx_r - IDX_W'(1);
          wr_data   = key_r;
          state_nxt = S_RESP;
        end else if (hit) begin
          res_nxt = '{status: ST_OK, position: POS_W'(idx_r),
                      comparisons: CMPS_W'(idx_r) + CMPS_W'(1)};
          if (trans_r && idx_r != '0) begin
            wr_en    = 1'b1;
            wr_addr  = idx_r;
            wr_data  = prev_r;
            tput_nxt = 1'b1;
          end else begin
            state_nxt = S_RESP;
          end
        end else if (CNT_W'(idx_r) + CNT_W'(1) == cnt_r) begin
          res_nxt   = '{status: ST_NOT_FOUND, position: '0, comparisons: '0};
          state_nxt = S_RESP;
        end else begin
          prev_nxt = rdata_r;
          idx_nxt  = idx_r + IDX_W'(1);
          rd_en    = 1'b1;
          rd_addr  = idx_r + IDX_W'(1);
        end
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      tput_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      tput_r  <= tput_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    steps_r <= steps_nxt;
    key_r   <= key_nxt;
    prev_r  <= prev_nxt;
    trans_r <= trans_nxt;
    res_r   <= res_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

endmodule

// ===== hw/rtl/key_table_insert_search.sv =====
// Top level of the key table: configuration registers, sequencer and result register.
`timescale 1ns / 1ps

// This block keeps a table of up to DEPTH signed keys in a memory with one read and one
// write port together with a fill count, and serves four operations selected by
// in_tuser: sorted insert or append, binary search over the filled range, linear search
// from the front, and a transpose search that swaps a found key with its predecessor.
// It works on one item at a time; in_tready is low from the cycle after an item is
// accepted until its result moves into the output register. Because the key memory
// gives one read per cycle, the cost of an item follows the entries it touches. An append,
// a full table or a linear search of an empty table is answered without a read, and a
// binary search of an empty table finds its range empty; a sorted insert shifts every
// larger entry up one place before it writes the key; a binary search reads one entry
// per halving step; a linear search reads from the front until the key or the end of
// the count, and a transpose adds a second write. The result register lets the next
// item be accepted while a result waits to be taken. The memory needs no clearing
// after reset since the fill count bounds every read. Configuration writes are taken
// at any time on the cfg port and must only be issued while idle.
module key_table_insert_search import kti_pkg::*; #(
  parameter int DEPTH    = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CFG_IDX_W-1:0]               cfg_addr,
  input  logic [CFG_DATA_W-1:0]              cfg_data,
  // Input item channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((KEY_BITS+7)/8)*8-1:0]      in_tdata,   // key
  input  logic [FUNC_W-1:0]                  in_tuser,   // func
  // Result item channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [OUT_TDATA_W-1:0]             out_tdata,  // position, comparisons, zero pad
  output logic [ST_W-1:0]                    out_tuser   // status
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                  ordered_r;
  logic [CFG_DATA_W-1:0] capacity_r;
  logic [CNT_W-1:0]      cap_eff;
  kti_ctl_t              ctl;
  logic                  res_valid, res_ready;
  kti_res_t              res;
  logic                  out_valid_r;
  kti_res_t              out_res_r;

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ordered_r  <= 1'b1;
      capacity_r <= CAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_ORDERED:  ordered_r  <= cfg_data[0];
        REG_CAPACITY: capacity_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Writing a one to the clear register empties the table; the keys stay but lie
  // outside the count.
  assign ctl.ordered = ordered_r;
  assign ctl.clear   = cfg_valid && (cfg_addr == REG_CLEAR) && cfg_data[0];

  // A capacity above the memory depth acts as the depth.
  assign cap_eff = (32'(capacity_r) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity_r);

  kti_seq #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .cap       (cap_eff),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_key    (in_tdata[KEY_BITS-1:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: it reloads whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_res_r.comparisons, out_res_r.position};

endmodule

// ===== hw/rtl/kti_checker.sv =====
// Port-level checks of the key table, bound to its top level.
`timescale 1ns / 1ps

module kti_checker import kti_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [ST_W-1:0]        out_tuser
);

  // Only one item is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready stayed high after an item was accepted");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_NOT_FOUND || out_tuser == ST_FULL))
    else $error("result carries an unknown status");

  // Failed operations report zero position and comparisons.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0)
    else $error("failed result has nonzero fields");

endmodule

bind key_table_insert_search kti_checker u_kti_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
